// ----- sv/alcdf_pkg.sv -----
// Shared types, constants and table functions for the asymmetric Laplace CDF evaluator.
// Has no dependencies; the ROM module and the top level import it.
package alcdf_pkg;

  localparam int unsigned ExpTableBitsDef = 8;
  localparam int unsigned MaxTableBits    = 12;

  localparam int unsigned FixW    = 32;   // Q16.16 sample, location and reciprocal scales
  localparam int unsigned ProbW   = 17;   // Q1.16 weight and probability
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ExpW    = 33;   // Q0.32 with room for exactly 1.0

  localparam logic [ProbW-1:0] OneQ16   = 17'd65536;
  localparam logic [16:0]      Log2eQ16 = 17'd94548;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOCATION        = 2'd0,
    CFG_INV_LEFT_SCALE  = 2'd1,
    CFG_INV_RIGHT_SCALE = 2'd2,
    CFG_LEFT_WEIGHT     = 2'd3
  } cfg_reg_e;

  // Integer square root of a 64-bit value, bit-pair method.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // Entry i approximates 2^(-i / 2^bits) in Q0.32; entry 0 is exactly 1.0.
  function automatic logic [ExpW-1:0] exp_rom_entry(input int unsigned i,
                                                    input int unsigned bits);
    logic [63:0] c [0:MaxTableBits];
    logic [63:0] p;
    c[0] = 64'd1 << 31;
    for (int k = 1; k <= MaxTableBits; k++) begin
      c[k] = isqrt64(c[k-1] << 32);
    end
    p = 64'd1 << 32;
    for (int j = 0; j < MaxTableBits; j++) begin
      if (j < bits && ((i >> j) & 1) == 1) begin
        p = (p * c[bits - j]) >> 32;
      end
    end
    if (i == 0) return {1'b1, 32'd0};
    if (p > 64'hFFFF_FFFF) return {1'b0, 32'hFFFF_FFFF};
    return {1'b0, p[31:0]};
  endfunction

endpackage

// ----- sv/alcdf_exp_rom.sv -----
// Fraction table for the 2^-f approximation, registered read.
// Depends on alcdf_pkg for the table contents function.
module alcdf_exp_rom #(
  parameter int unsigned TableBits = alcdf_pkg::ExpTableBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [TableBits-1:0]        idx_i,
  output logic [alcdf_pkg::ExpW-1:0]  data_o
);
  import alcdf_pkg::*;

  localparam int unsigned Depth = 2 ** TableBits;

  logic [ExpW-1:0] rom_tbl [Depth];
  logic [ExpW-1:0] data_q;

  for (genvar g = 0; g < Depth; g++) begin : g_tbl
    assign rom_tbl[g] = exp_rom_entry(g, TableBits);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= rom_tbl[idx_i];
  end

  assign data_o = data_q;

endmodule

// ----- sv/asymmetric_laplace_cdf_eval.sv -----
// Asymmetric Laplace cumulative distribution evaluator, six-stage pipeline.
// Depends on alcdf_pkg and alcdf_exp_rom.
//
// Usage:
//   Input channel: sample_i (signed Q16.16) with in_valid_i; the block drives
//   in_stall_o. A transaction happens on a clock edge with valid high and stall low.
//   Output channel: probability_o (unsigned Q1.16, at most 1.0) with out_valid_o;
//   the receiver drives out_stall_i.
//   Configuration: cfg_we_i, cfg_index_i and cfg_data_i write location, the two
//   reciprocal scales and the left weight; write only while the pipeline is empty.
//   The pipeline stages are subtract, 32x32 scale multiply, log2(e) multiply,
//   table read, shift and weight multiply; each registers its result, and a
//   result can be taken at the output once it has passed through all of them.
//   Throughput is one sample per cycle while the receiver does not stall.
//   Each stage has its own valid bit and moves whenever the stage after it can
//   take its contents, so bubbles are squeezed out and a stalled receiver only
//   stalls the input once all six stages hold data.
//   Reset empties the pipeline and restores the configuration defaults
//   (location 0, both reciprocal scales 1.0, left weight 0.5).
module asymmetric_laplace_cdf_eval #(
  parameter int unsigned EXP_TABLE_BITS = alcdf_pkg::ExpTableBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [alcdf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [alcdf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [alcdf_pkg::FixW-1:0] sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [alcdf_pkg::ProbW-1:0]     probability_o
);
  import alcdf_pkg::*;

  localparam int unsigned NumStages = 6;
  localparam int unsigned TW = 2 * FixW;   // Q32.32 product
  localparam int unsigned T16W = 20;       // Q4.16 truncated exponent argument
  localparam int unsigned UW = T16W + 17;  // Q5.32 after log2(e)
  localparam int unsigned NW = UW - 32;    // integer part of the power of two

  // Configuration registers.
  logic signed [FixW-1:0] location_q;
  logic [FixW-1:0]        inv_left_q, inv_right_q;
  logic [ProbW-1:0]       left_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      location_q    <= '0;
      inv_left_q    <= FixW'(65536);
      inv_right_q   <= FixW'(65536);
      left_weight_q <= ProbW'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LOCATION:        location_q    <= cfg_data_i;
        CFG_INV_LEFT_SCALE:  inv_left_q    <= cfg_data_i;
        CFG_INV_RIGHT_SCALE: inv_right_q   <= cfg_data_i;
        CFG_LEFT_WEIGHT:     left_weight_q <= cfg_data_i[ProbW-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain; ready[1] gates the input channel.
  logic [NumStages:1] valid_q;
  logic [NumStages+1:1] ready;

  assign ready[NumStages+1] = !out_stall_i;
  for (genvar k = 1; k <= NumStages; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_stall_o = !ready[1];

  // Stage 1: distance from the location and branch select.
  logic signed [FixW:0] diff;
  logic [FixW:0]        diff_neg;
  logic                 right_d;
  logic [FixW-1:0]      dist_d, scale_d;
  logic [ProbW-1:0]     wl_sat, weight_d;

  always_comb begin
    diff     = {sample_i[FixW-1], sample_i} - {location_q[FixW-1], location_q};
    diff_neg = -diff;
    right_d  = !diff[FixW] && (diff != '0);
    dist_d   = right_d ? diff[FixW-1:0] : diff_neg[FixW-1:0];
    scale_d  = right_d ? inv_right_q : inv_left_q;
    wl_sat   = (left_weight_q > OneQ16) ? OneQ16 : left_weight_q;
    weight_d = right_d ? (OneQ16 - wl_sat) : wl_sat;
  end

  logic [FixW-1:0]  dist_q, scale_q;
  logic [ProbW-1:0] w1_q, w2_q, w3_q, w4_q, w5_q, w6_q;
  logic [NumStages:1] right_q;

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      dist_q     <= dist_d;
      scale_q    <= scale_d;
      w1_q       <= weight_d;
    end
  end

  // Weight and branch flag follow the data through every stage.
  always_ff @(posedge clk_i) begin
    if (ready[1]) right_q[1] <= right_d;
    if (ready[2]) begin w2_q <= w1_q; right_q[2] <= right_q[1]; end
    if (ready[3]) begin w3_q <= w2_q; right_q[3] <= right_q[2]; end
    if (ready[4]) begin w4_q <= w3_q; right_q[4] <= right_q[3]; end
    if (ready[5]) begin w5_q <= w4_q; right_q[5] <= right_q[4]; end
    if (ready[6]) begin w6_q <= w5_q; right_q[6] <= right_q[5]; end
  end

  // Stage 2: t = distance times reciprocal scale, Q32.32.
  logic [TW-1:0] t_d, t_q;
  assign t_d = TW'(dist_q) * TW'(scale_q);

  always_ff @(posedge clk_i) begin
    if (ready[2]) t_q <= t_d;
  end

  // Stage 3: convert to a base-two exponent; t of 16 or more flushes to zero.
  logic          zero_d;
  logic [UW-1:0] u_d, u_q;
  logic          zero3_q, zero4_q;

  assign zero_d = |t_q[TW-1:36];
  assign u_d    = UW'(t_q[35:16]) * UW'(Log2eQ16);

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      u_q     <= u_d;
      zero3_q <= zero_d;
    end
  end

  // Stage 4: table read of the fractional power; integer part rides alongside.
  logic [NW-1:0]   n_q;
  logic [ExpW-1:0] base;

  alcdf_exp_rom #(
    .TableBits(EXP_TABLE_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (ready[4]),
    .idx_i (u_q[31 -: EXP_TABLE_BITS]),
    .data_o(base)
  );

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      n_q     <= u_q[UW-1:32];
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: apply the integer part as a right shift.
  logic [ExpW-1:0] e_d, e_q;
  assign e_d = zero4_q ? '0 : (base >> n_q);

  always_ff @(posedge clk_i) begin
    if (ready[5]) e_q <= e_d;
  end

  // Stage 6: weight, round half up to Q1.16, fold the right branch.
  localparam int unsigned PW = ExpW + ProbW;
  logic [PW-1:0]    prod;
  logic [PW-33:0]   term;
  logic [ProbW-1:0] term_sat, prob_d, prob_q;

  always_comb begin
    prod     = PW'(e_q) * PW'(w5_q) + PW'(64'd1 << 31);
    term     = prod[PW-1:32];
    term_sat = (term > (PW-32)'(OneQ16)) ? OneQ16 : term[ProbW-1:0];
    prob_d   = right_q[5] ? (OneQ16 - term_sat) : term_sat;
  end

  always_ff @(posedge clk_i) begin
    if (ready[6]) prob_q <= prob_d;
  end

  assign out_valid_o   = valid_q[NumStages];
  assign probability_o = prob_q;

  // Checks on the datapath and the stall chain.
  property p_prob_range;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> (probability_o <= OneQ16);
  endproperty
  a_prob_range: assert property (p_prob_range) else $error("probability above 1.0");

  property p_left_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !right_q[6]) |-> (probability_o <= w6_q);
  endproperty
  a_left_bound: assert property (p_left_bound) else $error("left result above weight");

  property p_stall_full;
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (&valid_q && out_stall_i);
  endproperty
  a_stall_full: assert property (p_stall_full) else $error("input stalled with a bubble");

endmodule
